// ===== rtl/amau_pkg.sv =====
// Shared types and constants of the multiply-accumulate unit.
`timescale 1ns / 1ps
package amau_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DWordW = 2 * WordW;
  localparam int unsigned HalfW = WordW / 2;
  // signed operand is one bit wider than a word; a half slice is one bit wider than a half
  localparam int unsigned OpW = WordW + 1;
  localparam int unsigned SliceW = HalfW + 1;
  localparam int unsigned PartW = OpW + SliceW;

  // mode bits that travel alongside the datapath
  typedef struct packed {
    logic is_long;
    logic upd_flags;
  } ctl_t;

endpackage

// ===== rtl/amau_mul.sv =====
// Multiplier stages: two signed partial products, then their combination.
`timescale 1ns / 1ps
module amau_mul
  import amau_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                action_i,
  input  logic                signed_mode_i,
  input  logic                accumulate_i,
  input  logic                update_flags_i,
  input  logic [WordW-1:0]    operand_m_i,
  input  logic [WordW-1:0]    operand_s_i,
  input  logic [WordW-1:0]    acc_low_i,
  input  logic [WordW-1:0]    acc_high_i,
  output logic                valid_o,
  input  logic                stall_i,
  output ctl_t                ctl_o,
  output logic [DWordW-1:0]   prod_o,
  output logic [DWordW-1:0]   acc_o
);

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  ctl_t                     ctl1_q, ctl2_q;
  logic signed [PartW-1:0]  pp_lo_d, pp_lo_q;
  logic signed [PartW-1:0]  pp_hi_d, pp_hi_q;
  logic [DWordW-1:0]        acc1_d, acc1_q, acc2_q;
  logic [DWordW-1:0]        prod_d, prod_q;
  logic signed [OpW-1:0]    m_ext, s_ext;
  logic signed [SliceW-1:0] s_lo, s_hi;
  logic                     sx;

  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  // sign extension only for signed long multiplies; the low word is sign-agnostic
  assign sx    = action_i & signed_mode_i;
  assign m_ext = $signed({sx & operand_m_i[WordW-1], operand_m_i});
  assign s_ext = $signed({sx & operand_s_i[WordW-1], operand_s_i});
  assign s_lo  = $signed({1'b0, operand_s_i[HalfW-1:0]});
  assign s_hi  = s_ext[OpW-1:HalfW];

  assign pp_lo_d = PartW'(m_ext) * PartW'(s_lo);
  assign pp_hi_d = PartW'(m_ext) * PartW'(s_hi);

  always_comb begin
    acc1_d = '0;
    if (accumulate_i) begin
      acc1_d[WordW-1:0] = acc_low_i;
      if (action_i) begin
        acc1_d[DWordW-1:WordW] = acc_high_i;
      end
    end
  end

  assign prod_d = {{(DWordW-PartW){pp_lo_q[PartW-1]}}, pp_lo_q}
                + ({{(DWordW-PartW){pp_hi_q[PartW-1]}}, pp_hi_q} << HalfW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      ctl1_q  <= '{is_long: action_i, upd_flags: update_flags_i};
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      acc1_q  <= acc1_d;
    end
    if (en2 && v1_q) begin
      ctl2_q <= ctl1_q;
      prod_q <= prod_d;
      acc2_q <= acc1_q;
    end
  end

  assign valid_o = v2_q;
  assign ctl_o   = ctl2_q;
  assign prod_o  = prod_q;
  assign acc_o   = acc2_q;

endmodule

// ===== rtl/amau_acc.sv =====
// Accumulate stage and flag/result output register.
`timescale 1ns / 1ps
module amau_acc
  import amau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  ctl_t               ctl_i,
  input  logic [DWordW-1:0]  prod_i,
  input  logic [DWordW-1:0]  acc_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [WordW-1:0]   result_low_o,
  output logic [WordW-1:0]   result_high_o,
  output logic               write_high_o,
  output logic               flags_update_o,
  output logic               flag_neg_o,
  output logic               flag_zero_o
);

  logic               v3_q, v4_q;
  logic               en3, en4;
  ctl_t               ctl3_q;
  logic [DWordW-1:0]  sum_q;
  logic [WordW-1:0]   res_hi_d;
  logic               neg_d, zero_d;
  logic [WordW-1:0]   res_lo_q, res_hi_q;
  logic               wr_hi_q, upd_q, neg_q, zero_q;

  assign en4     = !v4_q || !stall_i;
  assign en3     = !v3_q || en4;
  assign stall_o = !en3;

  // short mode keeps only the low word; its carry is dropped
  always_comb begin
    if (ctl3_q.is_long) begin
      res_hi_d = sum_q[DWordW-1:WordW];
      neg_d    = sum_q[DWordW-1];
      zero_d   = (sum_q == '0);
    end else begin
      res_hi_d = '0;
      neg_d    = sum_q[WordW-1];
      zero_d   = (sum_q[WordW-1:0] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      ctl3_q <= ctl_i;
      sum_q  <= prod_i + acc_i;
    end
    if (en4 && v3_q) begin
      res_lo_q <= sum_q[WordW-1:0];
      res_hi_q <= res_hi_d;
      wr_hi_q  <= ctl3_q.is_long;
      upd_q    <= ctl3_q.upd_flags;
      neg_q    <= ctl3_q.upd_flags & neg_d;
      zero_q   <= ctl3_q.upd_flags & zero_d;
    end
  end

  assign valid_o        = v4_q;
  assign result_low_o   = res_lo_q;
  assign result_high_o  = res_hi_q;
  assign write_high_o   = wr_hi_q;
  assign flags_update_o = upd_q;
  assign flag_neg_o     = neg_q;
  assign flag_zero_o    = zero_q;

endmodule

// ===== rtl/arm_multiply_accumulate_unit_top.sv =====
// Top level of the ARM multiply-accumulate datapath (MUL/MLA/UMULL/UMLAL/SMULL/SMLAL).
//
// Input channel: in_valid_i / in_stall_o with one transaction per multiply:
//   mode bits, operand_m, operand_s and the accumulator words acc_low/acc_high.
// Output channel: out_valid_o / out_stall_i, one result transaction per input:
//   result_low/high, write_high (long mode), flags_update and the N/Z flags.
// A transaction moves on a rising edge with valid high and stall low.
//
// Four register stages: partial products (m times each half of s),
// product combine, 64-bit accumulate, flag evaluation into the output register.
// Throughput is one transaction per cycle while out_stall_i is low; the 33x17
// partial-product multipliers set the critical path.
//
// Each stage holds a valid bit and advances when it is empty or the stage after
// it advances, so a stall at the output backs up stage by stage with nothing
// lost or repeated; in_stall_o rises only when all four stages are full and
// out_stall_i is high. Reset (rst_ni low, asynchronous) empties the pipeline;
// the block holds no other state, and in_stall_o is low straight after reset.
`timescale 1ns / 1ps
module arm_multiply_accumulate_unit_top
  import amau_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic              signed_mode_i,
  input  logic              accumulate_i,
  input  logic              update_flags_i,
  input  logic [WordW-1:0]  operand_m_i,
  input  logic [WordW-1:0]  operand_s_i,
  input  logic [WordW-1:0]  acc_low_i,
  input  logic [WordW-1:0]  acc_high_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WordW-1:0]  result_low_o,
  output logic [WordW-1:0]  result_high_o,
  output logic              write_high_o,
  output logic              flags_update_o,
  output logic              flag_neg_o,
  output logic              flag_zero_o
);

  // handshake between multiplier and accumulate halves
  logic               mid_valid;
  logic               mid_stall;
  ctl_t               mid_ctl;
  logic [DWordW-1:0]  mid_prod;
  logic [DWordW-1:0]  mid_acc;

  amau_mul u_mul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .stall_o        (in_stall_o),
    .action_i       (action_i),
    .signed_mode_i  (signed_mode_i),
    .accumulate_i   (accumulate_i),
    .update_flags_i (update_flags_i),
    .operand_m_i    (operand_m_i),
    .operand_s_i    (operand_s_i),
    .acc_low_i      (acc_low_i),
    .acc_high_i     (acc_high_i),
    .valid_o        (mid_valid),
    .stall_i        (mid_stall),
    .ctl_o          (mid_ctl),
    .prod_o         (mid_prod),
    .acc_o          (mid_acc)
  );

  amau_acc u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (mid_valid),
    .stall_o        (mid_stall),
    .ctl_i          (mid_ctl),
    .prod_i         (mid_prod),
    .acc_i          (mid_acc),
    .valid_o        (out_valid_o),
    .stall_i        (out_stall_i),
    .result_low_o   (result_low_o),
    .result_high_o  (result_high_o),
    .write_high_o   (write_high_o),
    .flags_update_o (flags_update_o),
    .flag_neg_o     (flag_neg_o),
    .flag_zero_o    (flag_zero_o)
  );

endmodule
